[rtl/core/tlt_pkg.sv]
// Package for the trapezoidal line trajectory core: widths, phase codes and
// configuration register indexes. No dependencies.
package tlt_pkg;

    localparam int TIME_BITS = 16;
    localparam int POS_BITS  = 22;
    localparam int NUM_AXES  = 3;

    localparam int CFG_W     = (POS_BITS > TIME_BITS) ? POS_BITS : TIME_BITS;
    localparam int CFG_IDX_W = 3;

    localparam logic [TIME_BITS-1:0] TICKS_RESET = TIME_BITS'(1000);

    // Multiplier operands: the first holds up to 7*T, the second up to T.
    localparam int MUL_W    = TIME_BITS + 3;
    // Scaled fraction numerator (at most 7*T^2) and the square of T.
    localparam int NUM_W    = 2 * TIME_BITS + 3;
    localparam int SQ_W     = 2 * TIME_BITS;
    localparam int NUM_LO_W = (NUM_W + 1) / 2;
    localparam int NUM_HI_W = NUM_W - NUM_LO_W;

    localparam int MAG_W    = POS_BITS;
    localparam int DIFF_W   = POS_BITS + 1;
    localparam int PROD_W   = MAG_W + NUM_W;
    localparam int DIVD_W   = PROD_W + 2;
    localparam int QUOT_W   = POS_BITS;

    // Stage layout: four front stages, the rounding add, one stage per
    // quotient bit, then the output register.
    localparam int FRONT_STG = 4;
    localparam int PIPE_STG  = QUOT_W + 1;
    localparam int NSTG      = FRONT_STG + PIPE_STG + 1;

    typedef enum logic [1:0] {
        PH_ACCEL  = 2'd0,
        PH_CRUISE = 2'd1,
        PH_DECEL  = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_X    = 3'd0,
        REG_START_Y    = 3'd1,
        REG_START_Z    = 3'd2,
        REG_END_X      = 3'd3,
        REG_END_Y      = 3'd4,
        REG_END_Z      = 3'd5,
        REG_MOVE_TICKS = 3'd6
    } cfg_reg_t;

endpackage

[rtl/core/trapezoid_line_trajectory_core.sv]
// Trapezoidal-profile straight-line trajectory core, fully pipelined.
// Depends on tlt_pkg for widths, phase codes and register indexes.
//
// Usage: write the start point, end point and move duration through the
// configuration port (cfg_we, cfg_index, cfg_data) while no words are in
// flight. Each input word carries a time_tick; each output word carries the
// position on the line for that tick and the phase of the speed profile
// (accelerate, cruise, decelerate, done). Past the move the end point is held.
// Positions are rounded to the nearest micrometre, halves away from zero.
//
// Every axis offset is D * num / (8*T^2), with num chosen per phase. The
// numerator comes from one multiplier, the product with the axis distance is
// built from two partial products, and the quotient comes from a restoring
// divider that resolves one bit per stage, so 28 register stages separate
// input from output. One word can enter every cycle while in_stall is low,
// so throughput is one word per cycle.
//
// A stall on the output holds the output register; the stages behind it keep
// moving until they fill, and in_stall rises only when every stage holds a
// word and the output is stalled. Reset empties the pipeline and loads the
// register defaults: start and end at the origin, a move of 1000 ticks.
module trapezoid_line_trajectory_core
    import tlt_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [TIME_BITS-1:0]        time_tick,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [POS_BITS-1:0]  pos_x,
    output logic signed [POS_BITS-1:0]  pos_y,
    output logic signed [POS_BITS-1:0]  pos_z,
    output logic [1:0]                  phase
);

    // Configuration registers
    logic signed [POS_BITS-1:0] start_reg [NUM_AXES];
    logic signed [POS_BITS-1:0] end_reg   [NUM_AXES];
    logic [TIME_BITS-1:0]       ticks_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                start_reg[a] <= '0;
                end_reg[a]   <= '0;
            end
            ticks_reg <= TICKS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_START_X:    start_reg[0] <= cfg_data[POS_BITS-1:0];
                REG_START_Y:    start_reg[1] <= cfg_data[POS_BITS-1:0];
                REG_START_Z:    start_reg[2] <= cfg_data[POS_BITS-1:0];
                REG_END_X:      end_reg[0]   <= cfg_data[POS_BITS-1:0];
                REG_END_Y:      end_reg[1]   <= cfg_data[POS_BITS-1:0];
                REG_END_Z:      end_reg[2]   <= cfg_data[POS_BITS-1:0];
                REG_MOVE_TICKS: ticks_reg    <= cfg_data[TIME_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // Values derived from the configuration, registered behind the configuration
    // registers, so they settle well before any word that follows a write needs them.
    logic [SQ_W-1:0]            tsq_reg;
    logic [MAG_W-1:0]           mag_reg  [NUM_AXES];
    logic                       neg_reg  [NUM_AXES];
    logic signed [DIFF_W-1:0]   diff     [NUM_AXES];
    logic [MAG_W-1:0]           mag_next [NUM_AXES];

    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            diff[a] = DIFF_W'(end_reg[a]) - DIFF_W'(start_reg[a]);
            if (diff[a][DIFF_W-1])
                mag_next[a] = MAG_W'(-diff[a]);
            else
                mag_next[a] = MAG_W'(diff[a]);
        end
    end

    always_ff @(posedge clk)
    begin
        tsq_reg <= ticks_reg * ticks_reg;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            mag_reg[a] <= mag_next[a];
            neg_reg[a] <= diff[a][DIFF_W-1];
        end
    end

    // Stage valids and the ready of each stage. A stage may load when the
    // output moves or some stage at or after it is empty.
    logic [FRONT_STG-1:0] v_reg;
    logic [QUOT_W:0]      dv_reg;
    logic                 out_valid_reg;
    logic [NSTG-1:0]      chain_v;
    logic [NSTG-1:0]      stg_rdy;

    assign chain_v = {out_valid_reg, dv_reg, v_reg};

    for (genvar g = 0; g < NSTG; g++)
    begin : g_rdy
        assign stg_rdy[g] = !out_stall || !(&chain_v[NSTG-1:g]);
    end

    assign in_stall  = !stg_rdy[0];
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            dv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (stg_rdy[0])
                v_reg[0] <= in_valid;
            for (int k = 1; k < FRONT_STG; k++)
            begin
                if (stg_rdy[k])
                    v_reg[k] <= v_reg[k-1];
            end
            if (stg_rdy[FRONT_STG])
                dv_reg[0] <= v_reg[FRONT_STG-1];
            for (int p = 1; p <= QUOT_W; p++)
            begin
                if (stg_rdy[FRONT_STG+p])
                    dv_reg[p] <= dv_reg[p-1];
            end
            if (stg_rdy[NSTG-1])
                out_valid_reg <= dv_reg[QUOT_W];
        end
    end

    // Stage 1: phase decision and multiplier operands.
    logic [MUL_W-1:0]     t5;
    logic [MUL_W-1:0]     ticks_x;
    logic [MUL_W-1:0]     ticks4;
    logic [MUL_W:0]       t10m;
    logic [TIME_BITS-1:0] t_left;
    logic [MUL_W-1:0]     v5;
    phase_t               s1_phase_next;
    logic [MUL_W-1:0]     s1_m1_next;
    logic [TIME_BITS-1:0] s1_m2_next;

    always_comb
    begin
        t5      = MUL_W'({time_tick, 2'b00}) + MUL_W'(time_tick);
        ticks_x = MUL_W'(ticks_reg);
        ticks4  = MUL_W'({ticks_reg, 2'b00});
        t10m    = {t5, 1'b0} - (MUL_W + 1)'(ticks_reg);
        t_left  = ticks_reg - time_tick;
        v5      = MUL_W'({t_left, 2'b00}) + MUL_W'(t_left);

        if (time_tick >= ticks_reg)
            s1_phase_next = PH_DONE;
        else if (t5 <= ticks_x)
            s1_phase_next = PH_ACCEL;
        else if (t5 <= ticks4)
            s1_phase_next = PH_CRUISE;
        else
            s1_phase_next = PH_DECEL;

        // Cruise uses (10t - T) * T over 8*T^2 so that all phases share one
        // denominator.
        case (s1_phase_next)
            PH_ACCEL:
            begin
                s1_m1_next = t5;
                s1_m2_next = t5[TIME_BITS-1:0];
            end
            PH_CRUISE:
            begin
                s1_m1_next = t10m[MUL_W-1:0];
                s1_m2_next = ticks_reg;
            end
            PH_DECEL:
            begin
                s1_m1_next = v5;
                s1_m2_next = v5[TIME_BITS-1:0];
            end
            default:
            begin
                s1_m1_next = '0;
                s1_m2_next = '0;
            end
        endcase
    end

    phase_t               s1_phase_reg;
    logic [MUL_W-1:0]     s1_m1_reg;
    logic [TIME_BITS-1:0] s1_m2_reg;
    phase_t               s2_phase_reg;
    logic [NUM_W-1:0]     s2_num_reg;
    phase_t               s3_phase_reg;
    logic [MAG_W+NUM_LO_W-1:0] s3_lo_reg [NUM_AXES];
    logic [MAG_W+NUM_HI_W-1:0] s3_hi_reg [NUM_AXES];
    phase_t               s4_phase_reg;
    logic [PROD_W-1:0]    s4_prod_reg [NUM_AXES];

    always_ff @(posedge clk)
    begin
        if (stg_rdy[0])
        begin
            s1_phase_reg <= s1_phase_next;
            s1_m1_reg    <= s1_m1_next;
            s1_m2_reg    <= s1_m2_next;
        end
        if (stg_rdy[1])
        begin
            s2_phase_reg <= s1_phase_reg;
            s2_num_reg   <= s1_m1_reg * s1_m2_reg;
        end
        if (stg_rdy[2])
        begin
            s3_phase_reg <= s2_phase_reg;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                s3_lo_reg[a] <= mag_reg[a] * s2_num_reg[NUM_LO_W-1:0];
                s3_hi_reg[a] <= mag_reg[a] * s2_num_reg[NUM_W-1:NUM_LO_W];
            end
        end
        if (stg_rdy[3])
        begin
            s4_phase_reg <= s3_phase_reg;
            for (int a = 0; a < NUM_AXES; a++)
                s4_prod_reg[a] <= PROD_W'(s3_lo_reg[a])
                                + (PROD_W'(s3_hi_reg[a]) << NUM_LO_W);
        end
    end

    // Rounding add and restoring divider. The dividend is 2P + D and the
    // divisor 2D, which gives round(P / D) with halves up on the magnitude.
    logic [DIVD_W-1:0] drem_next [QUOT_W+1][NUM_AXES];
    logic [QUOT_W-1:0] dq_next   [QUOT_W+1][NUM_AXES];
    logic [DIVD_W-1:0] drem_reg  [QUOT_W+1][NUM_AXES];
    logic [QUOT_W-1:0] dq_reg    [QUOT_W+1][NUM_AXES];
    phase_t            dph_reg   [QUOT_W+1];
    logic [DIVD_W-1:0] trial     [QUOT_W+1];
    logic              fits      [QUOT_W+1][NUM_AXES];

    always_comb
    begin
        trial[0] = '0;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            fits[0][a]      = 1'b0;
            drem_next[0][a] = DIVD_W'({s4_prod_reg[a], 1'b0})
                            + DIVD_W'({tsq_reg, 3'b000});
            dq_next[0][a]   = '0;
        end
        for (int p = 1; p <= QUOT_W; p++)
        begin
            trial[p] = DIVD_W'({tsq_reg, 4'b0000}) << (QUOT_W - p);
            for (int a = 0; a < NUM_AXES; a++)
            begin
                fits[p][a] = drem_reg[p-1][a] >= trial[p];
                if (fits[p][a])
                    drem_next[p][a] = drem_reg[p-1][a] - trial[p];
                else
                    drem_next[p][a] = drem_reg[p-1][a];
                dq_next[p][a] = {dq_reg[p-1][a][QUOT_W-2:0], fits[p][a]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_rdy[FRONT_STG])
        begin
            dph_reg[0] <= s4_phase_reg;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                drem_reg[0][a] <= drem_next[0][a];
                dq_reg[0][a]   <= dq_next[0][a];
            end
        end
        for (int p = 1; p <= QUOT_W; p++)
        begin
            if (stg_rdy[FRONT_STG+p])
            begin
                dph_reg[p] <= dph_reg[p-1];
                for (int a = 0; a < NUM_AXES; a++)
                begin
                    drem_reg[p][a] <= drem_next[p][a];
                    dq_reg[p][a]   <= dq_next[p][a];
                end
            end
        end
    end

    // Output stage: apply the signed offset from the start or the end point.
    logic signed [DIFF_W-1:0]   off  [NUM_AXES];
    logic signed [DIFF_W-1:0]   psum [NUM_AXES];
    logic signed [POS_BITS-1:0] pos_next [NUM_AXES];
    logic signed [POS_BITS-1:0] pos_reg  [NUM_AXES];
    phase_t                     out_phase_reg;

    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            if (neg_reg[a])
                off[a] = -$signed({1'b0, dq_reg[QUOT_W][a]});
            else
                off[a] = $signed({1'b0, dq_reg[QUOT_W][a]});
            case (dph_reg[QUOT_W])
                PH_DECEL: psum[a] = DIFF_W'(end_reg[a]) - off[a];
                PH_DONE:  psum[a] = DIFF_W'(end_reg[a]);
                default:  psum[a] = DIFF_W'(start_reg[a]) + off[a];
            endcase
            pos_next[a] = psum[a][POS_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_rdy[NSTG-1])
        begin
            out_phase_reg <= dph_reg[QUOT_W];
            for (int a = 0; a < NUM_AXES; a++)
                pos_reg[a] <= pos_next[a];
        end
    end

    assign pos_x = pos_reg[0];
    assign pos_y = pos_reg[1];
    assign pos_z = pos_reg[2];
    assign phase = out_phase_reg;

`ifndef NO_ASSERTIONS
    // A word leaving the output always frees room for a new input word.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |-> !in_stall)
        else $error("input stalled while the output drains");

    // Past the move the output must sit on the end point.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_phase_reg == PH_DONE |->
            pos_x == end_reg[0] && pos_y == end_reg[1] && pos_z == end_reg[2])
        else $error("done phase does not hold the end point");

    // The rounded offset never exceeds the distance along its axis.
    assert property (@(posedge clk) disable iff (!rst_n)
        dv_reg[QUOT_W] && dph_reg[QUOT_W] != PH_DONE |->
            dq_reg[QUOT_W][0] <= mag_reg[0] && dq_reg[QUOT_W][1] <= mag_reg[1]
            && dq_reg[QUOT_W][2] <= mag_reg[2])
        else $error("divider quotient exceeds the axis distance");
`endif

endmodule
